FILE: hdl/ubx_frame_parser_unit_defines.svh
// Assertion macros used by the port-level frame parser checker
`ifndef UBX_FRAME_PARSER_UNIT_DEFINES_SVH
`define UBX_FRAME_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define UBXFP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ubx frame parser: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define UBXFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ubx frame parser: next-cycle check failed");

`endif

FILE: hdl/ubxfp_pkg.sv
// Package: constants and result type of the frame parser
`default_nettype none

package ubxfp_pkg;

    localparam logic [7:0]  SYNC_FIRST       = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND      = 8'h62;
    localparam logic [15:0] MAX_PAYLOAD_INIT = 16'hFFFF;

    typedef struct packed {
        logic        payload_valid;
        logic [15:0] payload_index;
        logic [7:0]  payload_byte;
        logic        frame_done;
        logic        checksum_ok;
        logic        truncated;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] msg_length;
    } result_t;

endpackage

`default_nettype wire

FILE: hdl/ubxfp_core.sv
// Frame parser state machine and running Fletcher checksum
`default_nettype none

module ubxfp_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               in_fire,
    input  logic [7:0]         rx_byte,
    output ubxfp_pkg::result_t result
);
    import ubxfp_pkg::*;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_SYNC2,
        ST_CLASS,
        ST_ID,
        ST_LEN0,
        ST_LEN1,
        ST_BODY,
        ST_CHKB
    } state_t;

    state_t      state_reg, state_next;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  id_reg, id_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  recv_a_reg, recv_a_next;
    logic        cut_reg, cut_next;
    logic [15:0] max_payload_reg;
    logic [7:0]  add_a;
    logic [7:0]  add_b;

    assign add_a = sum_a_reg + rx_byte;
    assign add_b = sum_b_reg + add_a;

    always_comb
    begin
        state_next  = state_reg;
        class_next  = class_reg;
        id_next     = id_reg;
        length_next = length_reg;
        count_next  = count_reg;
        sum_a_next  = sum_a_reg;
        sum_b_next  = sum_b_reg;
        recv_a_next = recv_a_reg;
        cut_next    = cut_reg;
        result      = '0;

        unique case (state_reg)
            ST_HUNT:
            begin
                if (rx_byte == SYNC_FIRST)
                begin
                    state_next = ST_SYNC2;
                end
            end
            ST_SYNC2:
            begin
                state_next = (rx_byte == SYNC_SECOND) ? ST_CLASS : ST_HUNT;
            end
            ST_CLASS:
            begin
                class_next = rx_byte;
                sum_a_next = rx_byte;
                sum_b_next = rx_byte;
                state_next = ST_ID;
            end
            ST_ID:
            begin
                id_next    = rx_byte;
                sum_a_next = add_a;
                sum_b_next = add_b;
                state_next = ST_LEN0;
            end
            ST_LEN0:
            begin
                length_next = {8'h00, rx_byte};
                sum_a_next  = add_a;
                sum_b_next  = add_b;
                state_next  = ST_LEN1;
            end
            ST_LEN1:
            begin
                length_next = {rx_byte, length_reg[7:0]};
                sum_a_next  = add_a;
                sum_b_next  = add_b;
                count_next  = '0;
                cut_next    = 1'b0;
                state_next  = ST_BODY;
            end
            ST_BODY:
            begin
                if ((count_reg < length_reg) && (count_reg < max_payload_reg))
                begin
                    result.payload_valid = 1'b1;
                    result.payload_index = count_reg;
                    result.payload_byte  = rx_byte;
                    sum_a_next           = add_a;
                    sum_b_next           = add_b;
                    count_next           = count_reg + 16'd1;
                end
                else
                begin
                    cut_next    = (count_reg < length_reg);
                    recv_a_next = rx_byte;
                    state_next  = ST_CHKB;
                end
            end
            ST_CHKB:
            begin
                result.frame_done  = 1'b1;
                result.checksum_ok = (recv_a_reg == sum_a_reg) && (rx_byte == sum_b_reg);
                result.truncated   = cut_reg;
                state_next         = ST_HUNT;
            end
        endcase

        result.msg_class  = class_next;
        result.msg_id     = id_next;
        result.msg_length = length_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_HUNT;
            class_reg       <= '0;
            id_reg          <= '0;
            length_reg      <= '0;
            count_reg       <= '0;
            sum_a_reg       <= '0;
            sum_b_reg       <= '0;
            recv_a_reg      <= '0;
            cut_reg         <= 1'b0;
            max_payload_reg <= MAX_PAYLOAD_INIT;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_payload_reg <= cfg_wr_data;
            end
            if (in_fire)
            begin
                state_reg  <= state_next;
                class_reg  <= class_next;
                id_reg     <= id_next;
                length_reg <= length_next;
                count_reg  <= count_next;
                sum_a_reg  <= sum_a_next;
                sum_b_reg  <= sum_b_next;
                recv_a_reg <= recv_a_next;
                cut_reg    <= cut_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/ubxfp_out_buf.sv
// Output register with skid stage for parser results
`default_nettype none

module ubxfp_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  ubxfp_pkg::result_t in_data,
    output logic               full,
    output logic               out_valid,
    input  logic               out_stall,
    output ubxfp_pkg::result_t out_data
);
    import ubxfp_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    out_take;

    assign out_take  = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (out_take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (in_fire)
            begin
                out_valid_next = 1'b1;
                out_data_next  = in_data;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_fire)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

FILE: hdl/ubx_frame_parser_unit.sv
// Top level of the sync-framed binary frame parser
// Input channel: one received byte per transaction on rx_byte, with in_valid
// and in_stall. Output channel: one result per input byte, with out_valid and
// out_stall; payload_valid marks payload bytes, frame_done marks the second
// checksum byte together with checksum_ok and truncated. msg_class, msg_id
// and msg_length show the header of the current or last frame.
// Configuration: cfg_wr_en writes cfg_wr_data into max_payload; write it only
// while no transaction is in flight.
// Each result is registered in the output or, under a stall, the skid stage.
// Throughput: one byte per cycle while in_stall is low; the parser update and
// both 8-bit checksum adds are combinational ahead of the output register.
// Stall: a result waiting under out_stall holds steady; one more byte is
// taken into the skid stage, then in_stall rises until the output drains.
// Reset: hunts for the first sync byte, max_payload returns to 65535, the
// output and skid stages are emptied.
`default_nettype none

module ubx_frame_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        payload_valid,
    output logic [15:0] payload_index,
    output logic [7:0]  payload_byte,
    output logic        frame_done,
    output logic        checksum_ok,
    output logic        truncated,
    output logic [7:0]  msg_class,
    output logic [7:0]  msg_id,
    output logic [15:0] msg_length
);
    import ubxfp_pkg::*;

    logic    in_fire;
    logic    buf_full;
    result_t core_result;
    result_t out_result;

    assign in_stall = buf_full;
    assign in_fire  = in_valid && !buf_full;

    ubxfp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_fire     (in_fire),
        .rx_byte     (rx_byte),
        .result      (core_result)
    );

    ubxfp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_data   (core_result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_result)
    );

    assign payload_valid = out_result.payload_valid;
    assign payload_index = out_result.payload_index;
    assign payload_byte  = out_result.payload_byte;
    assign frame_done    = out_result.frame_done;
    assign checksum_ok   = out_result.checksum_ok;
    assign truncated     = out_result.truncated;
    assign msg_class     = out_result.msg_class;
    assign msg_id        = out_result.msg_id;
    assign msg_length    = out_result.msg_length;

endmodule

`default_nettype wire

FILE: hdl/ubxfp_checker.sv
// Port-level checker for the frame parser, bound to the top level
`default_nettype none
`include "ubx_frame_parser_unit_defines.svh"

module ubxfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_wr_en,
    input logic [15:0] cfg_wr_data,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  rx_byte,
    input logic        out_valid,
    input logic        out_stall,
    input logic        payload_valid,
    input logic [15:0] payload_index,
    input logic [7:0]  payload_byte,
    input logic        frame_done,
    input logic        checksum_ok,
    input logic        truncated,
    input logic [7:0]  msg_class,
    input logic [7:0]  msg_id,
    input logic [15:0] msg_length
);

    `UBXFP_ASSERT_IMPLY(a_done_not_payload, clk, rst_n, out_valid && frame_done, !payload_valid)
    `UBXFP_ASSERT_IMPLY(a_flags_need_done, clk, rst_n, out_valid && (checksum_ok || truncated), frame_done)
    `UBXFP_ASSERT_IMPLY(a_index_in_length, clk, rst_n, out_valid && payload_valid, payload_index < msg_length)
    `UBXFP_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && out_stall, out_valid && $stable(payload_index) && $stable(frame_done) && $stable(msg_length))

endmodule

bind ubx_frame_parser_unit ubxfp_checker u_ubxfp_checker (.*);

`default_nettype wire

FILE: tb/sv/ubx_frame_parser_unit_checker.sv
// Checker for the frame parser: mirrors the parser state and compares every result transaction
`default_nettype none

module ubx_frame_parser_unit_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic        payload_valid,
    input  wire logic [15:0] payload_index,
    input  wire logic [7:0]  payload_byte,
    input  wire logic        frame_done,
    input  wire logic        checksum_ok,
    input  wire logic        truncated,
    input  wire logic [7:0]  msg_class,
    input  wire logic [7:0]  msg_id,
    input  wire logic [15:0] msg_length,
    output logic      [31:0] fail_count,
    output logic      [31:0] pending
);
    import ubxfp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_SYNC2,
        ST_CLASS,
        ST_ID,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_BODY,
        ST_CK_B
    } parse_state_e;

    parse_state_e state;
    logic [7:0]   cls_q;
    logic [7:0]   id_q;
    logic [15:0]  len_q;
    logic [15:0]  count_q;
    logic [15:0]  limit_q;
    logic [7:0]   run_a;
    logic [7:0]   run_b;
    logic [7:0]   first_ck;
    logic         cut_q;
    result_t      awaited_results[$];

    function automatic void fold_byte(input logic [7:0] b);
        run_a = run_a + b;
        run_b = run_b + run_a;
    endfunction

    function automatic result_t parse_byte(input logic [7:0] b);
        result_t r;
        r = '0;
        case (state)
            ST_HUNT:
            begin
                if (b == SYNC_FIRST)
                    state = ST_SYNC2;
            end
            ST_SYNC2:
            begin
                state = (b == SYNC_SECOND) ? ST_CLASS : ST_HUNT;
            end
            ST_CLASS:
            begin
                cls_q = b;
                run_a = 8'h00;
                run_b = 8'h00;
                fold_byte(b);
                state = ST_ID;
            end
            ST_ID:
            begin
                id_q = b;
                fold_byte(b);
                state = ST_LEN_LO;
            end
            ST_LEN_LO:
            begin
                len_q = {8'h00, b};
                fold_byte(b);
                state = ST_LEN_HI;
            end
            ST_LEN_HI:
            begin
                len_q = {b, len_q[7:0]};
                fold_byte(b);
                count_q = 16'h0000;
                cut_q = 1'b0;
                state = ST_BODY;
            end
            ST_BODY:
            begin
                if (count_q < len_q && count_q < limit_q)
                begin
                    r.payload_valid = 1'b1;
                    r.payload_index = count_q;
                    r.payload_byte = b;
                    fold_byte(b);
                    count_q = count_q + 16'd1;
                end
                else
                begin
                    cut_q = (count_q < len_q);
                    first_ck = b;
                    state = ST_CK_B;
                end
            end
            default:
            begin
                r.frame_done = 1'b1;
                r.checksum_ok = (first_ck == run_a) && (b == run_b);
                r.truncated = cut_q;
                state = ST_HUNT;
            end
        endcase
        r.msg_class = cls_q;
        r.msg_id = id_q;
        r.msg_length = len_q;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            fail_count = fail_count + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t seen;
        result_t want;
        if (!rst_n)
        begin
            state = ST_HUNT;
            cls_q = 8'h00;
            id_q = 8'h00;
            len_q = 16'h0000;
            count_q = 16'h0000;
            limit_q = MAX_PAYLOAD_INIT;
            run_a = 8'h00;
            run_b = 8'h00;
            first_ck = 8'h00;
            cut_q = 1'b0;
            awaited_results.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen = {payload_valid, payload_index, payload_byte, frame_done,
                        checksum_ok, truncated, msg_class, msg_id, msg_length};
                if (awaited_results.size() == 0)
                begin
                    $error("result transaction with no received byte awaiting it");
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("payload_valid", 16'(want.payload_valid),
                                16'(seen.payload_valid));
                    check_field("payload_index", want.payload_index, seen.payload_index);
                    check_field("payload_byte", 16'(want.payload_byte),
                                16'(seen.payload_byte));
                    check_field("frame_done", 16'(want.frame_done), 16'(seen.frame_done));
                    check_field("checksum_ok", 16'(want.checksum_ok),
                                16'(seen.checksum_ok));
                    check_field("truncated", 16'(want.truncated), 16'(seen.truncated));
                    check_field("msg_class", 16'(want.msg_class), 16'(seen.msg_class));
                    check_field("msg_id", 16'(want.msg_id), 16'(seen.msg_id));
                    check_field("msg_length", want.msg_length, seen.msg_length);
                end
            end
            if (in_valid && !in_stall)
                awaited_results.push_back(parse_byte(rx_byte));
            if (cfg_wr_en)
                limit_q = cfg_wr_data;
            pending = awaited_results.size();
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/ubx_frame_parser_unit_tb.sv
// Testbench top for the frame parser: byte stimulus, output stalls and the verdict
`default_nettype none

module ubx_frame_parser_unit_tb;
    import ubxfp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STUCK_LIMIT = 2000;
    localparam int PHASE_ITEMS = 280;
    localparam int HOLD_CYCLES = 80;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic        payload_valid;
    logic [15:0] payload_index;
    logic [7:0]  payload_byte;
    logic        frame_done;
    logic        checksum_ok;
    logic        truncated;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] msg_length;
    logic [31:0] chk_fails;
    logic [31:0] chk_pending;

    logic        quiet_in;
    logic        quiet_out;
    logic        squeeze_req;
    logic        squeezed;
    logic [15:0] cur_max;
    logic [7:0]  run_a;
    logic [7:0]  run_b;
    int          items_sent;
    int          frames_sent;
    int          bad_frames;
    int          cut_frames;
    int          stray_bytes;
    int          settings_used;
    int          idle_cycles;
    int          phase_end;
    int          limits[6];

    ubx_frame_parser_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .payload_valid (payload_valid),
        .payload_index (payload_index),
        .payload_byte  (payload_byte),
        .frame_done    (frame_done),
        .checksum_ok   (checksum_ok),
        .truncated     (truncated),
        .msg_class     (msg_class),
        .msg_id        (msg_id),
        .msg_length    (msg_length)
    );

    ubx_frame_parser_unit_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .payload_valid (payload_valid),
        .payload_index (payload_index),
        .payload_byte  (payload_byte),
        .frame_done    (frame_done),
        .checksum_ok   (checksum_ok),
        .truncated     (truncated),
        .msg_class     (msg_class),
        .msg_id        (msg_id),
        .msg_length    (msg_length),
        .fail_count    (chk_fails),
        .pending       (chk_pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic push_byte(input logic [7:0] b);
        while (!quiet_in && $urandom_range(99) < 20)
        begin
            in_valid = 1'b0;
            rx_byte = 8'($urandom);
            @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte = b;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        @(negedge clk);
        in_valid = 1'b0;
        items_sent++;
    endtask

    task automatic push_summed(input logic [7:0] b);
        push_byte(b);
        run_a = run_a + b;
        run_b = run_b + run_a;
    endtask

    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                              input logic [15:0] len, input bit bad);
        int n;
        n = (len < cur_max) ? int'(len) : int'(cur_max);
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        run_a = 8'h00;
        run_b = 8'h00;
        push_summed(cls);
        push_summed(id);
        push_summed(len[7:0]);
        push_summed(len[15:8]);
        for (int i = 0; i < n; i++)
            push_summed(8'($urandom));
        if (bad)
        begin
            if ($urandom_range(1) == 1)
                run_a = run_a ^ 8'(1 << $urandom_range(7));
            else
                run_b = run_b ^ 8'(1 << $urandom_range(7));
            bad_frames++;
        end
        if (len > cur_max)
            cut_frames++;
        frames_sent++;
        push_byte(run_a);
        push_byte(run_b);
    endtask

    task automatic random_unit();
        int r;
        logic [15:0] len;
        logic [7:0] b;
        r = $urandom_range(99);
        if (r < 72)
        begin
            if (cur_max <= 64 && $urandom_range(1) == 1)
                len = 16'($urandom);
            else if ($urandom_range(19) == 0)
                len = 16'($urandom_range(13, 64));
            else
                len = 16'($urandom_range(0, 12));
            send_frame(8'($urandom), 8'($urandom), len, $urandom_range(99) < 15);
        end
        else if (r < 84)
        begin
            push_byte(SYNC_FIRST);
            if ($urandom_range(1) == 1)
                b = SYNC_FIRST;
            else
            begin
                do
                begin
                    b = 8'($urandom);
                end
                while (b == SYNC_SECOND);
            end
            push_byte(b);
            stray_bytes += 2;
        end
        else
        begin
            repeat ($urandom_range(1, 5))
            begin
                do
                begin
                    b = 8'($urandom);
                end
                while (b == SYNC_FIRST);
                push_byte(b);
                stray_bytes++;
            end
        end
    endtask

    task automatic set_limit(input logic [15:0] v);
        in_valid = 1'b0;
        while (chk_pending != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        cur_max = v;
        settings_used++;
    endtask

    initial
    begin
        bit hold_now;
        bit calm;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            hold_now = squeeze_req;
            calm = quiet_out;
            @(negedge clk);
            if (hold_now)
            begin
                squeeze_req = 1'b0;
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_stall = calm ? 1'b0 : ($urandom_range(99) < 20);
        end
    end

    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 16'h0000;
        in_valid = 1'b0;
        rx_byte = 8'h00;
        quiet_in = 1'b0;
        quiet_out = 1'b0;
        squeeze_req = 1'b0;
        squeezed = 1'b0;
        cur_max = MAX_PAYLOAD_INIT;
        items_sent = 0;
        frames_sent = 0;
        bad_frames = 0;
        cut_frames = 0;
        stray_bytes = 0;
        settings_used = 0;
        limits = '{0, 65535, 1, 9, 0, 65535};
        limits[4] = $urandom_range(2, 40);
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_frame(8'h00, 8'h00, 16'h0000, 1'b0);
        send_frame(8'hFF, 8'hFF, 16'h0001, 1'b1);
        push_byte(SYNC_FIRST);
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        stray_bytes += 3;

        for (int p = 0; p < 6; p++)
        begin
            set_limit(16'(limits[p]));
            phase_end = items_sent + PHASE_ITEMS;
            if (p == 2)
            begin
                quiet_in = 1'b1;
                quiet_out = 1'b1;
            end
            while (items_sent < phase_end)
            begin
                if (p == 1 && !squeezed && items_sent >= phase_end - 180)
                begin
                    quiet_in = 1'b1;
                    squeeze_req = 1'b1;
                    squeezed = 1'b1;
                end
                if (p == 1 && items_sent >= phase_end - 60)
                    quiet_in = 1'b0;
                random_unit();
            end
            quiet_in = 1'b0;
            quiet_out = 1'b0;
        end

        in_valid = 1'b0;
        while (chk_pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("Sent %0d bytes: %0d frames, %0d with a corrupted checksum, %0d cut at max_payload.",
                 items_sent, frames_sent, bad_frames, cut_frames);
        $display("Also %0d stray or broken-sync bytes, %0d max_payload writes, one long output hold-off.",
                 stray_bytes, settings_used);
        if (chk_fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
